// File: rtl/scba_pkg.sv
// Package for the size class block allocator: constants, types and codes.
// No dependencies; every other file of the block but scba_if.sv imports it.
package scba_pkg;

  localparam int unsigned AlignBytes      = 8;
  localparam int unsigned NumClasses      = 16;
  localparam int unsigned ChunkLimitBytes = 4096;
  localparam int unsigned MaxBlocks       = 64;
  localparam int unsigned HeapBytes       = 65536;

  localparam int unsigned LinkDepth = HeapBytes / AlignBytes;
  localparam int unsigned IdxW      = $clog2(LinkDepth);
  localparam int unsigned LinkW     = IdxW + 1;
  localparam int unsigned ClsW      = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int unsigned TopW      = $clog2(HeapBytes) + 1;
  localparam int unsigned CntW      = $clog2(MaxBlocks) + 1;
  localparam int unsigned AlignSh   = $clog2(AlignBytes);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_OOM      = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CARVE,
    S_READ,
    S_POP,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic carve_start;
    logic carve_step;
    logic read_link;
    logic pop;
    logic push;
    logic set_oom;
    logic out_push;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_size;
    logic is_free;
    logic head_valid;
    logic carve_ok;
    logic carve_last;
    logic blk_in_heap;
  } stat_t;

endpackage

// File: rtl/scba_if.sv
// Valid/ready channel interfaces carrying the allocator's transactions.
interface scba_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  size_bytes;
  logic [15:0] block_address;
  modport source (output valid, command, size_bytes, block_address, input ready);
  modport sink   (input valid, command, size_bytes, block_address, output ready);
endinterface

interface scba_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] granted_address;
  logic [1:0]  status;
  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface

// File: rtl/scba_ctrl.sv
// Controller state machine of the allocator; sequences decode, chunk carving,
// link read and list update. Depends on scba_pkg.
module scba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  scba_pkg::stat_t stat_i,
  output scba_pkg::ctrl_t ctrl_o
);
  import scba_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.bad_size) begin
          state_d = S_DONE;
        end else if (stat_i.is_free) begin
          ctrl_o.push = stat_i.blk_in_heap;
          state_d     = S_DONE;
        end else if (stat_i.head_valid) begin
          ctrl_o.read_link = 1'b1;
          state_d          = S_READ;
        end else if (stat_i.carve_ok) begin
          ctrl_o.carve_start = 1'b1;
          state_d            = S_CARVE;
        end else begin
          ctrl_o.set_oom = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_CARVE: begin
        ctrl_o.carve_step = 1'b1;
        if (stat_i.carve_last) begin
          state_d = S_DECODE;
        end
      end
      S_READ: begin
        state_d = S_POP;
      end
      S_POP: begin
        ctrl_o.pop = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_busy_i) begin
          ctrl_o.out_push = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: rtl/scba_dp.sv
// Datapath of the allocator: list heads, link memory, bump pointer, carve
// counter and output register. Depends on scba_pkg.
module scba_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            command_i,
  input  logic [7:0]      size_bytes_i,
  input  logic [15:0]     block_address_i,
  input  scba_pkg::ctrl_t ctrl_i,
  output scba_pkg::stat_t stat_o,
  output logic            out_busy_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     granted_address_o,
  output logic [1:0]      status_o
);
  import scba_pkg::*;

  logic [IdxW-1:0]  head_q [NumClasses];
  logic [NumClasses-1:0] hvalid_q;
  logic [LinkW-1:0] link_mem [LinkDepth];
  logic [LinkW-1:0] rdata_q;
  logic [TopW-1:0]  top_q;

  logic             cmd_q;
  logic [7:0]       size_q;
  logic [IdxW-1:0]  blk_q;
  logic             blk_ok_q;
  logic [ClsW-1:0]  cls;
  logic             bad;
  logic [7:0]       sm1;

  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  k_q;
  logic [IdxW:0]    at_q;
  logic [6:0]       stride;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  cnt_tab [NumClasses];
  logic [TopW+12:0] chunk_bytes;
  logic [TopW+12:0] room;

  logic             ov_q;
  logic [15:0]      oaddr_q;
  logic [IdxW-1:0]  gidx_q;
  status_e          ost_q;
  status_e          st_q;

  // Class decode of the latched request.
  assign sm1    = size_q - 8'd1;
  assign bad    = (size_q == 8'd0) || ((32'(sm1) >> AlignSh) >= NumClasses);
  assign cls    = ClsW'(32'(sm1) >> AlignSh);
  assign stride = 7'(cls) + 7'd1;

  // Per-class chunk sizing from a constant table.
  for (genvar c = 0; c < NumClasses; c++) begin : g_cnt
    localparam int unsigned ByLim = ChunkLimitBytes / ((c + 1) * AlignBytes);
    assign cnt_tab[c] = (ByLim < MaxBlocks) ? CntW'(ByLim) : CntW'(MaxBlocks);
  end
  assign count       = cnt_tab[cls];
  assign chunk_bytes = (TopW+13)'(count) * (TopW+13)'(stride) * (TopW+13)'(AlignBytes);
  assign room        = (TopW+13)'(HeapBytes) - (TopW+13)'(top_q);

  assign stat_o.bad_size    = bad;
  assign stat_o.is_free     = (cmd_q == CMD_FREE);
  assign stat_o.head_valid  = hvalid_q[cls];
  assign stat_o.carve_ok    = (count != '0) && (chunk_bytes <= room);
  assign stat_o.carve_last  = (k_q + CntW'(1) == cnt_q);
  assign stat_o.blk_in_heap = blk_ok_q;

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= command_i;
      size_q   <= size_bytes_i;
      blk_q    <= IdxW'(block_address_i >> AlignSh);
      blk_ok_q <= (32'(block_address_i) >> AlignSh) < LinkDepth;
    end
  end

  // Carve counter walks the chunk one block a cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.carve_start) begin
      cnt_q <= count;
      k_q   <= '0;
      at_q  <= (IdxW+1)'(top_q >> AlignSh);
    end else if (ctrl_i.carve_step) begin
      k_q  <= k_q + CntW'(1);
      at_q <= at_q + (IdxW+1)'(stride);
    end
  end

  // Link memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.carve_step && (at_q < (IdxW+1)'(LinkDepth))) begin
      link_mem[IdxW'(at_q)] <= stat_o.carve_last ? '0
                             : LinkW'(at_q + (IdxW+1)'(stride) + (IdxW+1)'(1));
    end else if (ctrl_i.push) begin
      link_mem[blk_q] <= hvalid_q[cls] ? LinkW'(head_q[cls]) + LinkW'(1) : '0;
    end
    if (ctrl_i.read_link) begin
      rdata_q <= link_mem[head_q[cls]];
    end
  end

  // List heads, valid flags and bump pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      top_q    <= '0;
      for (int c = 0; c < NumClasses; c++) head_q[c] <= '0;
    end else begin
      if (ctrl_i.carve_start) begin
        head_q[cls]   <= IdxW'(top_q >> AlignSh);
        hvalid_q[cls] <= 1'b1;
        top_q         <= top_q + TopW'(chunk_bytes);
      end else if (ctrl_i.push) begin
        head_q[cls]   <= blk_q;
        hvalid_q[cls] <= 1'b1;
      end else if (ctrl_i.pop) begin
        if (rdata_q == '0) hvalid_q[cls] <= 1'b0;
        else head_q[cls] <= IdxW'(rdata_q - LinkW'(1));
      end
    end
  end

  // Result build-up; the granted block is the head before the pop.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      st_q <= ST_OK;
    end else if (ctrl_i.set_oom) begin
      st_q <= ST_OOM;
    end
    if (ctrl_i.read_link) begin
      gidx_q <= head_q[cls];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctrl_i.out_push) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_push) begin
      if (bad) begin
        ost_q   <= ST_BAD_SIZE;
        oaddr_q <= '0;
      end else if (st_q == ST_OOM || cmd_q == CMD_FREE) begin
        ost_q   <= st_q;
        oaddr_q <= '0;
      end else begin
        ost_q   <= ST_OK;
        oaddr_q <= 16'(32'(gidx_q) << AlignSh);
      end
    end
  end

  assign out_busy_o        = ov_q && !out_ready_i;
  assign out_valid_o       = ov_q;
  assign granted_address_o = oaddr_q;
  assign status_o          = ost_q;

endmodule

// File: rtl/size_class_block_allocator_top.sv
// Size class block allocator, top level.
// A request is latched in S_IDLE and decoded; a pop then runs S_READ and S_POP, while
// a free or error goes straight to S_DONE; a carve walks the chunk one block a cycle
// (up to MaxBlocks) in S_CARVE and decodes again. S_DONE registers the result when the
// output register is free. One transaction at a time; the output register lets the next
// request enter while the last result waits. Reset clears lists and heap.
module size_class_block_allocator_top (
  input logic       clk_i,
  input logic       rst_ni,
  scba_req_if.sink  req,
  scba_rsp_if.source rsp
);
  import scba_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  busy;

  scba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_busy_i (busy),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  scba_dp u_dp (
    .clk_i, .rst_ni,
    .command_i         (req.command),
    .size_bytes_i      (req.size_bytes),
    .block_address_i   (req.block_address),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .out_busy_o        (busy),
    .out_valid_o       (rsp.valid),
    .out_ready_i       (rsp.ready),
    .granted_address_o (rsp.granted_address),
    .status_o          (rsp.status)
  );

  // Carving and pushing never happen together.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.carve_step && ctrl.push)) else $error("carve and push overlap");

  // A request is never loaded in the same cycle as a result is pushed.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> !ctrl.out_push) else $error("load with result");

  // Status never reports an undefined code.
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.status != 2'd3) else $error("bad status code");

endmodule

// File: sim/scba_checker.sv
// Checker for the size class block allocator: watches both channels,
// predicts each response from its own copy of the free lists and compares.
// Depends on scba_pkg and the channel interfaces in scba_if.sv.
`timescale 1ns / 100ps

module scba_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  scba_req_if        req,
  scba_rsp_if        rsp,
  output int         fail_count_o,
  output int         pending_o
);
  import scba_pkg::*;

  localparam int unsigned Blocks = HeapBytes / AlignBytes;

  typedef struct packed {
    logic [15:0] granted_address;
    status_e     status;
  } grant_t;

  // Shadow copy of the allocator state.
  logic [IdxW-1:0]  head_idx   [NumClasses];
  logic             head_live  [NumClasses];
  logic [LinkW-1:0] link_mem   [Blocks];
  logic [TopW-1:0]  bump_ptr;

  grant_t expected_grants[$];
  int     mismatches;

  // Carves a fresh chunk for a class; returns 0 when the heap cannot hold it.
  function automatic bit carve(input int unsigned cls);
    int unsigned node, chunk, count, base, at;
    node  = (cls + 1) * AlignBytes;
    count = ChunkLimitBytes / node;
    if (count > MaxBlocks) count = MaxBlocks;
    chunk = count * node;
    if (count == 0) return 0;
    if (bump_ptr > HeapBytes || chunk > HeapBytes - bump_ptr) return 0;
    base = bump_ptr / AlignBytes;
    for (int unsigned k = 0; k < count; k++) begin
      at = base + k * (cls + 1);
      if (at >= Blocks) break;
      link_mem[at] = (k + 1 < count) ? LinkW'(at + cls + 2) : '0;
    end
    head_idx[cls]  = IdxW'(base);
    head_live[cls] = 1'b1;
    bump_ptr       = bump_ptr + TopW'(chunk);
    return 1;
  endfunction

  // Works out the response to one request and updates the shadow state.
  function automatic grant_t predict_grant(input cmd_e cmd, input logic [7:0] size,
                                           input logic [15:0] addr);
    grant_t      g;
    int unsigned cls, head, lnk, blk;
    g.granted_address = '0;
    g.status          = ST_OK;
    if (size == 0 || (int'(size) - 1) / AlignBytes >= NumClasses) begin
      g.status = ST_BAD_SIZE;
      return g;
    end
    cls = (int'(size) - 1) / AlignBytes;
    if (cmd == CMD_ALLOC) begin
      if (!head_live[cls] && !carve(cls)) begin
        g.status = ST_OOM;
        return g;
      end
      head = head_idx[cls];
      lnk  = link_mem[head];
      if (lnk == 0) head_live[cls] = 1'b0;
      else head_idx[cls] = IdxW'(lnk - 1);
      g.granted_address = 16'(head * AlignBytes);
    end else begin
      blk = addr / AlignBytes;
      if (blk < Blocks) begin
        link_mem[blk]  = head_live[cls] ? LinkW'(head_idx[cls] + 1) : '0;
        head_idx[cls]  = IdxW'(blk);
        head_live[cls] = 1'b1;
      end
    end
    return g;
  endfunction

  // Responses are checked before the request of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumClasses; i++) begin
        head_idx[i]  = '0;
        head_live[i] = 1'b0;
      end
      for (int i = 0; i < Blocks; i++) link_mem[i] = '0;
      bump_ptr = '0;
      expected_grants.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with no transaction outstanding: addr %h status %0d",
                     $realtime, rsp.granted_address, rsp.status);
        end else begin
          want = expected_grants.pop_front();
          if (rsp.granted_address !== want.granted_address || rsp.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected addr %h status %0d, got addr %h status %0d",
                       $realtime, want.granted_address, want.status,
                       rsp.granted_address, rsp.status);
          end
        end
      end
      if (req.valid && req.ready)
        expected_grants.push_back(predict_grant(cmd_e'(req.command), req.size_bytes,
                                                req.block_address));
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o    = expected_grants.size();

endmodule

// File: sim/tb_top.sv
// Testbench top for the size class block allocator: clock, reset, stimulus
// and verdict. Depends on scba_pkg, scba_if.sv, the block and scba_checker.
`timescale 1ns / 100ps

module tb_top;
  import scba_pkg::*;

  localparam int StallLimit = 4000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   quiet_cycles;
  int   send_idle_pct;
  int   recv_idle_pct;

  // Sizes of sent requests in order, to pair each grant with its class.
  logic [7:0]  sent_sizes[$];
  cmd_e        sent_cmds[$];
  logic [15:0] live_addr[$];
  logic [7:0]  live_size[$];

  scba_req_if req ();
  scba_rsp_if rsp ();

  size_class_block_allocator_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp)
  );

  scba_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .rsp          (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn on every falling edge.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Track granted blocks so that most frees return real allocations.
  always @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      sent_sizes.push_back(req.size_bytes);
      sent_cmds.push_back(cmd_e'(req.command));
    end
    if (rsp.valid && rsp.ready && sent_sizes.size() > 0) begin
      if (sent_cmds[0] == CMD_ALLOC && rsp.status == ST_OK) begin
        live_addr.push_back(rsp.granted_address);
        live_size.push_back(sent_sizes[0]);
      end
      void'(sent_sizes.pop_front());
      void'(sent_cmds.pop_front());
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("size_class_block_allocator_top: mismatch");
      $finish;
    end
  end

  // Sends one request, idling first at the current rate, and holds it until taken.
  task automatic send(input cmd_e cmd, input logic [7:0] size, input logic [15:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid         = 1'b1;
    req.command       = cmd;
    req.size_bytes    = size;
    req.block_address = addr;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  // One random request: mostly well-formed allocations and matching frees.
  task automatic send_random();
    int pick, slot;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send(CMD_ALLOC, 8'($urandom_range(128, 1)), 16'($urandom));
    end else if (pick < 88 && live_addr.size() > 0) begin
      slot = $urandom_range(live_addr.size() - 1);
      send(CMD_FREE, live_size[slot], live_addr[slot]);
      live_addr.delete(slot);
      live_size.delete(slot);
    end else begin
      send(cmd_e'($urandom_range(1)), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    quiet_cycles      = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    req.valid         = 1'b0;
    req.command       = CMD_ALLOC;
    req.size_bytes    = '0;
    req.block_address = '0;
    rst_ni            = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: size limits, both commands, misaligned and repeated frees.
    send(CMD_ALLOC, 8'd0,   16'h0000);
    send(CMD_ALLOC, 8'd129, 16'h0000);
    send(CMD_ALLOC, 8'd255, 16'hFFFF);
    send(CMD_FREE,  8'd0,   16'h0010);
    send(CMD_FREE,  8'd200, 16'h0010);
    send(CMD_ALLOC, 8'd1,   16'hFFFF);
    send(CMD_ALLOC, 8'd8,   16'h0000);
    send(CMD_ALLOC, 8'd9,   16'h0000);
    send(CMD_ALLOC, 8'd128, 16'h0000);
    send(CMD_ALLOC, 8'd121, 16'h0000);
    send(CMD_FREE,  8'd8,   16'h0008);
    send(CMD_FREE,  8'd8,   16'h0008);
    send(CMD_ALLOC, 8'd8,   16'h0000);
    send(CMD_ALLOC, 8'd8,   16'h0000);
    send(CMD_FREE,  8'd16,  16'h0803);
    send(CMD_ALLOC, 8'd16,  16'h0000);
    send(CMD_FREE,  8'd64,  16'hFFFF);
    send(CMD_ALLOC, 8'd64,  16'h0000);
    send(CMD_FREE,  8'd128, 16'h0000);
    send(CMD_ALLOC, 8'd128, 16'h0000);
    send(CMD_ALLOC, 8'd128, 16'h0000);

    // Random traffic in three pressure phases.
    send_idle_pct = 17;
    recv_idle_pct = 52;
    repeat (615) send_random();
    send_idle_pct = 52;
    recv_idle_pct = 17;
    repeat (615) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (615) send_random();

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("size_class_block_allocator_top: match");
    end else begin
      $display("size_class_block_allocator_top: mismatch");
    end
    $finish;
  end

endmodule
